[rtl/idiv_pkg.sv]
// Shared types and constants for the integer divider.
`default_nettype none
package idiv_pkg;

  // Operand width used when wide mode is off
  localparam int NARROW_W = 32;

  // Operation codes carried on the request
  typedef enum logic [1:0] {
    OP_UQUO = 2'd0,
    OP_UREM = 2'd1,
    OP_SQUO = 2'd2,
    OP_SREM = 2'd3
  } op_t;

endpackage
`default_nettype wire

[rtl/idiv_sub.sv]
// Shared subtractor of the divider: difference and borrow out.
`default_nettype none
module idiv_sub #(
  parameter int W = 64
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              borrow
);

  logic [W:0] full;

  // One extra bit catches the borrow out of the top position
  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule
`default_nettype wire

[rtl/integer_divider_signed_unsigned_core.sv]
// Top level of the iterative signed/unsigned integer divider.
// Restoring divider for 32-bit or MAX_WIDTH-bit operands that returns the
// quotient or remainder, unsigned or signed (truncating toward zero, remainder
// takes the dividend's sign). One item is worked at a time and in_ready is low
// while it is in progress. An item passes an accept step, for signed operations
// a dividend and a divisor sign step, then a division step for each quotient
// bit (32, or MAX_WIDTH in wide mode) and a finishing step. A zero divisor
// skips the sign and division steps, going straight to the finishing step with
// divide_by_zero set and a zero answer. A single shared subtractor settles one
// quotient bit per cycle and also performs the sign negations. The result sits
// in an output register; a stalled output holds off only the finishing step.
`default_nettype none
module integer_divider_signed_unsigned_core #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic        in_wide_mode,
  input  wire logic [63:0] in_dividend,
  input  wire logic [63:0] in_divisor,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_answer,
  output logic             out_divide_by_zero
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int ALIGN = MAX_WIDTH - idiv_pkg::NARROW_W;
  localparam logic [MAX_WIDTH-1:0] NARROW_MASK = MAX_WIDTH'({idiv_pkg::NARROW_W{1'b1}});

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_NEG_N = 5'b00010,
    ST_NEG_D = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIX   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [MAX_WIDTH-1:0]  nq_r, nq_nxt;     // dividend bits out the top, quotient in
  logic [MAX_WIDTH-1:0]  rem_r, rem_nxt;
  logic [MAX_WIDTH-1:0]  d_r, d_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  idiv_pkg::op_t         op_r, op_nxt;
  logic                  wide_r, wide_nxt;
  logic                  dz_r, dz_nxt;
  logic                  nneg_r, nneg_nxt;
  logic                  dneg_r, dneg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           out_answer_r, out_answer_nxt;
  logic                  out_dz_r, out_dz_nxt;

  logic [MAX_WIDTH-1:0]  sub_a, sub_b, sub_diff;
  logic                  sub_borrow;
  logic [MAX_WIDTH-1:0]  in_mask, mask_w, in_n, in_d, rem_shift, fix_val, res;
  logic                  take, is_signed, is_quo, in_signed, neg_res;

  idiv_sub #(.W(MAX_WIDTH)) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // Operand masking and alignment on the request
  assign in_mask   = in_wide_mode ? '1 : NARROW_MASK;
  assign in_n      = in_wide_mode ? (in_dividend[MAX_WIDTH-1:0] & in_mask)
                                  : ((in_dividend[MAX_WIDTH-1:0] & in_mask) << ALIGN);
  assign in_d      = in_divisor[MAX_WIDTH-1:0] & in_mask;
  assign in_signed = (in_operation == idiv_pkg::OP_SQUO) ||
                     (in_operation == idiv_pkg::OP_SREM);

  assign mask_w    = wide_r ? '1 : NARROW_MASK;
  assign is_signed = (op_r == idiv_pkg::OP_SQUO) || (op_r == idiv_pkg::OP_SREM);
  assign is_quo    = (op_r == idiv_pkg::OP_UQUO) || (op_r == idiv_pkg::OP_SQUO);
  assign rem_shift = {rem_r[MAX_WIDTH-2:0], nq_r[MAX_WIDTH-1]};
  assign fix_val   = is_quo ? (nq_r & mask_w) : rem_r;
  assign neg_res   = is_signed && (is_quo ? (nneg_r ^ dneg_r) : nneg_r);
  assign take      = rem_r[MAX_WIDTH-1] | ~sub_borrow;
  assign res       = dz_r ? '0 : (neg_res ? (sub_diff & mask_w) : fix_val);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    nq_nxt         = nq_r;
    rem_nxt        = rem_r;
    d_nxt          = d_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    wide_nxt       = wide_r;
    dz_nxt         = dz_r;
    nneg_nxt       = nneg_r;
    dneg_nxt       = dneg_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_answer_nxt = out_answer_r;
    out_dz_nxt     = out_dz_r;
    sub_a          = '0;
    sub_b          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          nq_nxt   = in_n;
          d_nxt    = in_d;
          rem_nxt  = '0;
          op_nxt   = idiv_pkg::op_t'(in_operation);
          wide_nxt = in_wide_mode;
          dz_nxt   = (in_d == '0);
          nneg_nxt = in_n[MAX_WIDTH-1];
          dneg_nxt = in_wide_mode ? in_d[MAX_WIDTH-1] : in_d[idiv_pkg::NARROW_W-1];
          cnt_nxt  = in_wide_mode ? CW'(MAX_WIDTH) : CW'(idiv_pkg::NARROW_W);
          if (in_d == '0) begin
            state_nxt = ST_FIX;
          end else if (in_signed) begin
            state_nxt = ST_NEG_N;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_NEG_N: begin
        // aligned dividend: negating the whole word keeps the low zeros
        sub_b = nq_r;
        if (nneg_r) begin
          nq_nxt = sub_diff;
        end
        state_nxt = ST_NEG_D;
      end
      ST_NEG_D: begin
        sub_b = d_r;
        if (dneg_r) begin
          d_nxt = sub_diff & mask_w;
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one restoring step: shift, trial subtract, keep or restore
        sub_a   = rem_shift;
        sub_b   = d_r;
        rem_nxt = take ? sub_diff : rem_shift;
        nq_nxt  = {nq_r[MAX_WIDTH-2:0], take};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // sign fix-up and hand-off to the output register
        sub_b = fix_val;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = 64'(res);
          out_dz_nxt     = dz_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    nq_r         <= nq_nxt;
    rem_r        <= rem_nxt;
    d_r          <= d_nxt;
    cnt_r        <= cnt_nxt;
    op_r         <= op_nxt;
    wide_r       <= wide_nxt;
    dz_r         <= dz_nxt;
    nneg_r       <= nneg_nxt;
    dneg_r       <= dneg_nxt;
    out_answer_r <= out_answer_nxt;
    out_dz_r     <= out_dz_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_answer         = out_answer_r;
  assign out_divide_by_zero = out_dz_r;

endmodule
`default_nettype wire

[rtl/idiv_checker.sv]
// Port-level checks for the integer divider, bound to the top level.
`default_nettype none
module idiv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_answer,
  input wire logic        out_divide_by_zero
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_answer) &&
                                $stable(out_divide_by_zero))
    else $error("result changed while stalled");

  // Zero divisor always reports a zero answer
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_answer == 64'd0)
    else $error("nonzero answer on divide by zero");

  // Busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // No result can appear in the cycle right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind integer_divider_signed_unsigned_core idiv_checker u_idiv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_answer         (out_answer),
  .out_divide_by_zero (out_divide_by_zero)
);
`default_nettype wire
